// ===== hdl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helpers for the streaming 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int unsigned MAX_WIDTH  = 256;
   localparam int unsigned HEIGHT_MAX = 256;
   localparam int unsigned SIZE_MIN   = 3;

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned DIM_W    = 9;
   localparam int unsigned ADDR_W   = $clog2(MAX_WIDTH);
   localparam int unsigned COLSUM_W = PIX_W + 2;
   localparam int unsigned SUM_W    = PIX_W + 4;

   // floor(sum / 9) == (sum * 3641) >> 15 for every sum below 2^15
   localparam int unsigned RECIP       = 3641;
   localparam int unsigned RECIP_W     = 12;
   localparam int unsigned RECIP_SHIFT = 15;
   localparam int unsigned PROD_W      = SUM_W + RECIP_W;

   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned INFL_W     = 2;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             flush;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic              valid;
      logic              emit;
      logic              interior;
      logic              last;
      logic [PIX_W-1:0]  px;
      logic [ADDR_W-1:0] addr;
   } stage_type;

   function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                   input int unsigned hi);
      if (32'(v) < SIZE_MIN) begin
         return DIM_W'(SIZE_MIN);
      end
      if (32'(v) > hi) begin
         return DIM_W'(hi);
      end
      return v;
   endfunction

endpackage

// ===== hdl/box_blur_3x3_stream_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_top
// Streaming 3x3 mean filter for 8-bit grayscale frames in raster order.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_type {pixel_in, flush}
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_type {pixel_out, frame_last}
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One item per clock sustained while the result queue has room; each result passes
// line store read, window update, sum, then divide by 9 into the result queue.
// The line stores give one read and one write per cycle, which sets the rate.
// Reset is synchronous; no clearing pass, line stores hold no reset value.
// req_ready drops only when the 8-entry result queue plus the results in
// flight would overflow, so a stalled rsp side holds off input once 8 results
// are queued or in flight.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bb3_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bb3_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bb3_pkg::DIM_W-1:0]     csr_data
);
   import bb3_pkg::*;

   rd_req_type            rd_req;
   stage_type             stage;
   logic                  out_valid;
   rsp_type               out_data;
   logic [INFL_W-1:0]     inflight;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic                  accept;

   assign req_ready = (fifo_count + FIFO_CNT_W'(inflight)) < FIFO_CNT_W'(FIFO_DEPTH);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   bb3_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rd_req      (rd_req),
      .stage       (stage)
   );

   bb3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .rd_req    (rd_req),
      .stage     (stage),
      .out_valid (out_valid),
      .out_data  (out_data),
      .inflight  (inflight)
   );

   bb3_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (out_valid),
      .wr_data     (out_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .count       (fifo_count)
   );

endmodule

// ===== hdl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bb3_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3_ctrl
// Frame size registers, position and tail counters, line store read issue.
// ----------------------------------------------------------------------------
module bb3_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  bb3_pkg::req_type                 req_payload,
   input  logic                             csr_we,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bb3_pkg::DIM_W-1:0]        csr_data,
   output bb3_pkg::rd_req_type              rd_req,
   output bb3_pkg::stage_type               stage
);
   import bb3_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] pend_ff, pend_in;
   stage_type        stage_ff, stage_in;

   logic             fire;
   logic             restart;
   logic [DIM_W-1:0] col;
   logic [DIM_W-1:0] row;
   logic [DIM_W-1:0] qr;
   logic [DIM_W-1:0] qc;
   logic [DIM_W:0]   ncol;
   logic [DIM_W-1:0] nrow;
   logic [DIM_W-1:0] pend_dec;

   always_comb begin
      fire    = accept && !(req_payload.flush && pend_ff == '0);
      restart = !req_payload.flush && pend_ff != '0;
      col     = restart ? '0 : col_ff;
      row     = restart ? '0 : row_ff;

      if (col == '0) begin
         qr = row - DIM_W'(2);
         qc = width_ff - DIM_W'(1);
      end else begin
         qr = row - DIM_W'(1);
         qc = col - DIM_W'(1);
      end

      stage_in.valid    = fire;
      stage_in.emit     = (row >= DIM_W'(2)) || (row == DIM_W'(1) && col != '0);
      stage_in.interior = (qr != '0) && ((DIM_W+1)'(qr) + (DIM_W+1)'(2) <= (DIM_W+1)'(height_ff))
                       && (qc != '0) && ((DIM_W+1)'(qc) + (DIM_W+1)'(2) <= (DIM_W+1)'(width_ff));
      stage_in.last     = (qr == height_ff - DIM_W'(1)) && (qc == width_ff - DIM_W'(1));
      stage_in.px       = req_payload.flush ? '0 : req_payload.pixel_in;
      stage_in.addr     = ADDR_W'(col);

      rd_req.en   = fire;
      rd_req.addr = ADDR_W'(col);

      ncol     = (DIM_W+1)'(col) + (DIM_W+1)'(1);
      nrow     = row;
      pend_dec = pend_ff - DIM_W'(1);

      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;

      if (csr_we && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT)) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            width_in = clamp_size(csr_data, MAX_WIDTH);
         end else begin
            height_in = clamp_size(csr_data, HEIGHT_MAX);
         end
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (fire) begin
         if (ncol >= (DIM_W+1)'(width_ff)) begin
            col_in = '0;
            nrow   = row + DIM_W'(1);
         end else begin
            col_in = DIM_W'(ncol);
         end
         row_in = nrow;
         if (req_payload.flush) begin
            pend_in = pend_dec;
            if (pend_dec == '0) begin
               col_in = '0;
               row_in = '0;
            end
         end else if (nrow >= height_ff) begin
            pend_in = width_ff + DIM_W'(1);
         end else begin
            pend_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= clamp_size(DIM_W'(256), MAX_WIDTH);
         height_ff      <= clamp_size(DIM_W'(256), HEIGHT_MAX);
         col_ff         <= '0;
         row_ff         <= '0;
         pend_ff        <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pend_ff        <= pend_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.emit     <= stage_in.emit;
      stage_ff.interior <= stage_in.interior;
      stage_ff.last     <= stage_in.last;
      stage_ff.px       <= stage_in.px;
      stage_ff.addr     <= stage_in.addr;
   end

   assign stage = stage_ff;

endmodule

// ===== hdl/bb3_window.sv =====
// ----------------------------------------------------------------------------
// bb3_window
// Line stores with write-back forwarding, 3x3 window, sum and divide by 9.
// ----------------------------------------------------------------------------
module bb3_window (
   input  logic                       clock,
   input  logic                       reset,
   input  bb3_pkg::rd_req_type        rd_req,
   input  bb3_pkg::stage_type         stage,
   output logic                       out_valid,
   output bb3_pkg::rsp_type           out_data,
   output logic [bb3_pkg::INFL_W-1:0] inflight
);
   import bb3_pkg::*;

   logic [PIX_W-1:0]    rd_up;
   logic [PIX_W-1:0]    rd_mid;
   logic [PIX_W-1:0]    up;
   logic [PIX_W-1:0]    mid;
   logic                fwd;
   logic [COLSUM_W-1:0] colsum_new;

   logic                wr_valid_ff;
   logic [ADDR_W-1:0]   wr_addr_ff;
   logic [PIX_W-1:0]    wr_up_ff;
   logic [PIX_W-1:0]    wr_mid_ff;

   logic [COLSUM_W-1:0] cs0_ff, cs1_ff, cs2_ff;
   logic [PIX_W-1:0]    m1_ff, m2_ff;

   logic                p2_valid_ff;
   logic                p2_interior_ff;
   logic                p2_last_ff;
   logic [SUM_W-1:0]    sum;

   logic                p3_valid_ff;
   logic                p3_interior_ff;
   logic                p3_last_ff;
   logic [SUM_W-1:0]    p3_sum_ff;
   logic [PIX_W-1:0]    p3_center_ff;
   logic [PROD_W-1:0]   prod;

   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (stage.valid),
      .wr_addr (stage.addr),
      .wr_data (mid),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_up)
   );

   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (stage.valid),
      .wr_addr (stage.addr),
      .wr_data (stage.px),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_mid)
   );

   // read of an entry written in the same cycle returns old data
   always_comb begin
      fwd        = wr_valid_ff && (wr_addr_ff == stage.addr);
      up         = fwd ? wr_up_ff : rd_up;
      mid        = fwd ? wr_mid_ff : rd_mid;
      colsum_new = COLSUM_W'(up) + COLSUM_W'(mid) + COLSUM_W'(stage.px);
      sum        = SUM_W'(cs0_ff) + SUM_W'(cs1_ff) + SUM_W'(cs2_ff);
      prod       = PROD_W'(p3_sum_ff) * PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= stage.valid;
         p2_valid_ff <= stage.valid && stage.emit;
         p3_valid_ff <= p2_valid_ff;
      end
      wr_addr_ff <= stage.addr;
      wr_up_ff   <= mid;
      wr_mid_ff  <= stage.px;
      if (stage.valid) begin
         cs0_ff <= cs1_ff;
         cs1_ff <= cs2_ff;
         cs2_ff <= colsum_new;
         m1_ff  <= m2_ff;
         m2_ff  <= mid;
      end
      p2_interior_ff <= stage.interior;
      p2_last_ff     <= stage.last;
      p3_interior_ff <= p2_interior_ff;
      p3_last_ff     <= p2_last_ff;
      p3_sum_ff      <= sum;
      p3_center_ff   <= m1_ff;
   end

   assign out_valid           = p3_valid_ff;
   assign out_data.pixel_out  = p3_interior_ff ? PIX_W'(prod >> RECIP_SHIFT) : p3_center_ff;
   assign out_data.frame_last = p3_last_ff;
   assign inflight = INFL_W'(stage.valid && stage.emit) + INFL_W'(p2_valid_ff)
                   + INFL_W'(p3_valid_ff);

endmodule

// ===== hdl/bb3_fifo.sv =====
// ----------------------------------------------------------------------------
// bb3_fifo
// Result queue; decouples the filter pipeline from the result channel.
// ----------------------------------------------------------------------------
module bb3_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  bb3_pkg::rsp_type               wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bb3_pkg::rsp_type               rsp_payload,
   output logic [bb3_pkg::FIFO_CNT_W-1:0] count
);
   import bb3_pkg::*;

   rsp_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  rd_en;

   always_comb begin
      rd_en     = rsp_ready && (count_ff != '0);
      wr_ptr_in = wr_en ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(wr_en) - FIFO_CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign count       = count_ff;

endmodule
